@@ rtl/qau_pkg.sv @@
// ============================================================================
// qau_pkg: shared types and constants of the quaternion arithmetic unit
// opcode encoding of a request and the pipeline depth
// ============================================================================
package qau_pkg;

  // opcode field width
  localparam int unsigned FUNC_W = 3;

  // number of register stages from input to output register
  localparam int unsigned NUM_STAGES = 6;

  // operation codes; the spare code yields an all-zero result
  typedef enum logic [FUNC_W-1:0] {
    FUNC_ADD   = 3'd0,
    FUNC_SUB   = 3'd1,
    FUNC_MUL   = 3'd2,
    FUNC_ROT   = 3'd3,
    FUNC_CONJ  = 3'd4,
    FUNC_NEG   = 3'd5,
    FUNC_SCALE = 3'd6
  } func_e;

endpackage

@@ rtl/quaternion_arith_unit_core.sv @@
// ============================================================================
// quaternion_arith_unit_core: pipelined fixed-point quaternion unit
// add, subtract, hamilton product, vector rotation, conjugate, negate, scale
// ============================================================================
//
// usage
//   slave stream: one request per handshake. tuser carries the opcode, tdata
//   carries operand a (w, x, y, z) then operand b (w, x, y, z), each a signed
//   fixed-point word with FRAC_BITS fraction bits. for rotation, b.x..b.z is
//   the vector; for scale, b.w is the factor.
//   master stream: one result per request, in request order. tdata holds
//   w, x, y, z; tuser is set when any component was clamped to the word range.
//   products are kept exact, rounded to nearest (ties up) once, then clamped.
// pipeline
//   six register stages: one request can enter every cycle as long as a
//   stage has room (see stall below). the stages are the multiplier array,
//   product sums and rotation matrix, split rotation multipliers, row sums,
//   rounding adder and clamp/output register.
// reset
//   rst_ni clears all stage valid bits; the pipeline comes up empty.
// stall
//   when m_axis_tready is low the result holds; stages behind it keep moving
//   into empty slots, and s_axis_tready drops only once every stage is full.
//
module quaternion_arith_unit_core #(
  parameter int unsigned WORD_BITS = 32,
  parameter int unsigned FRAC_BITS = 24
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // request channel
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // qa_w, qa_x, qa_y, qa_z, qb_w, qb_x, qb_y, qb_z
  input  logic [8*WORD_BITS-1:0]                s_axis_tdata,
  // func
  input  logic [qau_pkg::FUNC_W-1:0]            s_axis_tuser,
  // result channel
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // res_w, res_x, res_y, res_z, zero fill to whole bytes
  output logic [((4*WORD_BITS+7)/8)*8-1:0]      m_axis_tdata,
  // saturated
  output logic                                  m_axis_tuser
);
  import qau_pkg::*;

  localparam int unsigned W      = WORD_BITS;
  localparam int unsigned F      = FRAC_BITS;
  localparam int unsigned OUT_DW = ((4*WORD_BITS+7)/8)*8;
  localparam int unsigned L_W    = W + 1;      // add, subtract, negate
  localparam int unsigned P_W    = 2*W;        // operand products
  localparam int unsigned C_W    = 2*W + 2;    // combined products, rotation matrix
  localparam int unsigned LP_W   = 2*W + 1;    // matrix low half times vector
  localparam int unsigned HP_W   = 2*W + 2;    // matrix high half times vector
  localparam int unsigned LS_W   = 2*W + 3;
  localparam int unsigned HS_W   = 2*W + 4;
  localparam int unsigned R_W    = 3*W + 5;    // full-precision result

  localparam logic signed [R_W-1:0] HALF_1 = R_W'(1) <<< (F - 1);
  localparam logic signed [R_W-1:0] HALF_2 = R_W'(1) <<< (2*F - 1);
  localparam logic [W-1:0] MAX_V = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MIN_V = {1'b1, {(W-1){1'b0}}};

  // --------------------------------------------------------------------------
  // stage valid bits and per-stage advance enables
  // a stage may load when it is empty or its content moves on
  // --------------------------------------------------------------------------
  logic [NUM_STAGES-1:0] v_q;
  logic [NUM_STAGES:0]   en;

  always_comb begin
    en[NUM_STAGES] = m_axis_tready;
    for (int k = NUM_STAGES - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= s_axis_tvalid;
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = v_q[NUM_STAGES-1];

  // --------------------------------------------------------------------------
  // stage 1: unpack, operand multiplier array, linear ops
  // for rotation the array forms the pairwise products of a with itself
  // --------------------------------------------------------------------------
  func_e                 func_in;
  logic signed [W-1:0]   in_a   [4];
  logic signed [W-1:0]   in_b   [4];
  logic signed [W-1:0]   mul_rhs[4];
  logic signed [P_W-1:0] pp_d   [4][4];
  logic signed [L_W-1:0] lin_d  [4];

  func_e                 func_q1;
  logic signed [P_W-1:0] pp_q1  [4][4];
  logic signed [L_W-1:0] lin_q1 [4];
  logic signed [W-1:0]   bv_q1  [3];

  assign func_in = func_e'(s_axis_tuser);

  always_comb begin
    logic signed [L_W-1:0] ea;
    logic signed [L_W-1:0] eb;
    for (int i = 0; i < 4; i++) begin
      in_a[i] = s_axis_tdata[i*W +: W];
      in_b[i] = s_axis_tdata[(i+4)*W +: W];
    end
    for (int i = 0; i < 4; i++) begin
      mul_rhs[i] = (func_in == FUNC_ROT) ? in_a[i] : in_b[i];
    end
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        pp_d[i][j] = P_W'(in_a[i]) * P_W'(mul_rhs[j]);
      end
    end
    for (int i = 0; i < 4; i++) begin
      ea = L_W'(in_a[i]);
      eb = L_W'(in_b[i]);
      case (func_in)
        FUNC_ADD:  lin_d[i] = ea + eb;
        FUNC_SUB:  lin_d[i] = ea - eb;
        FUNC_CONJ: lin_d[i] = (i == 0) ? ea : -ea;
        FUNC_NEG:  lin_d[i] = -ea;
        default:   lin_d[i] = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      func_q1 <= func_in;
      pp_q1   <= pp_d;
      lin_q1  <= lin_d;
      for (int j = 0; j < 3; j++) bv_q1[j] <= in_b[j+1];
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: product and scale sums, rotation matrix from a's products
  // --------------------------------------------------------------------------
  logic signed [C_W-1:0] e     [4][4];
  logic signed [C_W-1:0] comp_d[4];
  logic signed [C_W-1:0] m_d   [3][3];

  func_e                 func_q2;
  logic signed [C_W-1:0] comp_q2[4];
  logic signed [C_W-1:0] m_q2   [3][3];
  logic signed [W-1:0]   bv_q2  [3];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) e[i][j] = C_W'(pp_q1[i][j]);
    end
    case (func_q1) inside
      FUNC_ADD, FUNC_SUB, FUNC_CONJ, FUNC_NEG: begin
        for (int i = 0; i < 4; i++) comp_d[i] = C_W'(lin_q1[i]);
      end
      FUNC_MUL: begin
        comp_d[0] = e[0][0] - e[1][1] - e[2][2] - e[3][3];
        comp_d[1] = e[0][1] + e[1][0] + e[2][3] - e[3][2];
        comp_d[2] = e[0][2] - e[1][3] + e[2][0] + e[3][1];
        comp_d[3] = e[0][3] + e[1][2] - e[2][1] + e[3][0];
      end
      FUNC_SCALE: begin
        for (int i = 0; i < 4; i++) comp_d[i] = e[i][0];
      end
      default: begin
        for (int i = 0; i < 4; i++) comp_d[i] = '0;
      end
    endcase
    // rotation matrix rows x, y, z times vector columns x, y, z
    m_d[0][0] = e[0][0] + e[1][1] - e[2][2] - e[3][3];
    m_d[0][1] = (e[1][2] - e[0][3]) <<< 1;
    m_d[0][2] = (e[0][2] + e[1][3]) <<< 1;
    m_d[1][0] = (e[1][2] + e[0][3]) <<< 1;
    m_d[1][1] = e[0][0] - e[1][1] + e[2][2] - e[3][3];
    m_d[1][2] = (e[2][3] - e[0][1]) <<< 1;
    m_d[2][0] = (e[1][3] - e[0][2]) <<< 1;
    m_d[2][1] = (e[2][3] + e[0][1]) <<< 1;
    m_d[2][2] = e[0][0] - e[1][1] - e[2][2] + e[3][3];
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      func_q2 <= func_q1;
      comp_q2 <= comp_d;
      m_q2    <= m_d;
      bv_q2   <= bv_q1;
    end
  end

  // --------------------------------------------------------------------------
  // stage 3: matrix times vector, each entry split in a low and a high half
  // --------------------------------------------------------------------------
  logic signed [LP_W-1:0] lo_d[3][3];
  logic signed [HP_W-1:0] hi_d[3][3];

  func_e                  func_q3;
  logic signed [C_W-1:0]  comp_q3[4];
  logic signed [LP_W-1:0] lo_q3  [3][3];
  logic signed [HP_W-1:0] hi_q3  [3][3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        lo_d[r][c] = LP_W'($signed({1'b0, m_q2[r][c][W-1:0]})) * LP_W'(bv_q2[c]);
        hi_d[r][c] = HP_W'($signed(m_q2[r][c][C_W-1:W])) * HP_W'(bv_q2[c]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      func_q3 <= func_q2;
      comp_q3 <= comp_q2;
      lo_q3   <= lo_d;
      hi_q3   <= hi_d;
    end
  end

  // --------------------------------------------------------------------------
  // stage 4: per-row partial sums of the high and low halves
  // --------------------------------------------------------------------------
  logic signed [LS_W-1:0] ls_d[3];
  logic signed [HS_W-1:0] hs_d[3];

  func_e                  func_q4;
  logic signed [C_W-1:0]  comp_q4[4];
  logic signed [LS_W-1:0] ls_q4  [3];
  logic signed [HS_W-1:0] hs_q4  [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      ls_d[r] = LS_W'(lo_q3[r][0]) + LS_W'(lo_q3[r][1]) + LS_W'(lo_q3[r][2]);
      hs_d[r] = HS_W'(hi_q3[r][0]) + HS_W'(hi_q3[r][1]) + HS_W'(hi_q3[r][2]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      func_q4 <= func_q3;
      comp_q4 <= comp_q3;
      ls_q4   <= ls_d;
      hs_q4   <= hs_d;
    end
  end

  // --------------------------------------------------------------------------
  // stage 5: full-precision value, products rounded to nearest with ties up
  // --------------------------------------------------------------------------
  logic signed [R_W-1:0] val [4];
  logic signed [R_W-1:0] rnd_d[4];
  logic signed [R_W-1:0] rnd_q5[4];

  always_comb begin
    val[0] = R_W'(comp_q4[0]);
    for (int i = 1; i < 4; i++) begin
      if (func_q4 == FUNC_ROT) begin
        val[i] = (R_W'(hs_q4[i-1]) <<< W) + R_W'(ls_q4[i-1]);
      end else begin
        val[i] = R_W'(comp_q4[i]);
      end
    end
    for (int i = 0; i < 4; i++) begin
      case (func_q4) inside
        FUNC_MUL, FUNC_SCALE: rnd_d[i] = (val[i] + HALF_1) >>> F;
        FUNC_ROT:             rnd_d[i] = (val[i] + HALF_2) >>> (2*F);
        default:              rnd_d[i] = val[i];
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) rnd_q5 <= rnd_d;
  end

  // --------------------------------------------------------------------------
  // stage 6: clamp to the word range, output register
  // --------------------------------------------------------------------------
  logic [W-1:0] res_d[4];
  logic [3:0]   clip;
  logic [W-1:0] res_q6[4];
  logic         sat_q6;

  always_comb begin
    logic [R_W-W:0] top;
    for (int i = 0; i < 4; i++) begin
      top = rnd_q5[i][R_W-1:W-1];
      clip[i] = !((&top) || !(|top));
      if (!clip[i]) begin
        res_d[i] = rnd_q5[i][W-1:0];
      end else begin
        res_d[i] = rnd_q5[i][R_W-1] ? MIN_V : MAX_V;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      res_q6 <= res_d;
      sat_q6 <= |clip;
    end
  end

  assign m_axis_tdata = OUT_DW'({res_q6[3], res_q6[2], res_q6[1], res_q6[0]});
  assign m_axis_tuser = sat_q6;

`ifndef SYNTHESIS
  // a taken request always lands in the first stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> v_q[0])
    else $error("accepted request missing from first stage");

  // requests are only refused when no stage has a free slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (&v_q))
    else $error("request refused while a stage is empty");

  // rotation has no scalar part before rounding
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[1] && func_q2 == FUNC_ROT |-> comp_q2[0] == '0)
    else $error("rotation scalar part not zero");

  // a clamped result has at least one component at a bound
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      (res_q6[0] == MAX_V || res_q6[0] == MIN_V || res_q6[1] == MAX_V ||
       res_q6[1] == MIN_V || res_q6[2] == MAX_V || res_q6[2] == MIN_V ||
       res_q6[3] == MAX_V || res_q6[3] == MIN_V))
    else $error("saturation flag without a clamped component");
`endif

endmodule
